@@ rtl/rfd_pkg.sv @@
// Package for the ring FIFO with drain: operation and status codes,
// sequencer states and fixed field widths. No dependencies.
`default_nettype none

package rfd_pkg;

    localparam int OP_W     = 2;
    localparam int REC_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int CNT_OUT_W = 7;
    localparam int CAP_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_DRAIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_SLOT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/ring_fifo_with_drain_unit.sv @@
// Ring FIFO with drain: circular record store with enqueue, dequeue, clear
// and drain-to-slot operations, run by a small sequencer around one memory.
// Depends on rfd_pkg.
//
// Usage: a command word enters on i_in_valid/o_in_ready, results leave on
// o_out_valid/i_out_ready; both handshakes complete when valid and ready are
// high at a rising edge. The block holds one command at a time: o_in_ready
// is high only while idle. Enqueue, clear and refused commands go from
// S_EXEC straight to S_OUT; a dequeue passes S_READ between the two. A drain
// gives one result word per popped record, each through S_EXEC, S_READ (the
// registered read of the record memory) and S_OUT; a drain that pops nothing
// gives one word. The last word of each command carries o_last. A stalled
// receiver holds the current result word unchanged and the sequencer waits.
// The capacity register is written through i_cfg_wr_en/i_cfg_wr_data; the
// user must write it only while idle, as the block does not enforce this. It
// is saturated into 1..DEPTH when used. Synchronous reset empties the queue,
// sets capacity to DEPTH and returns the sequencer to idle; the record
// memory is not cleared and needs no clearing pass.
`default_nettype none

module ring_fifo_with_drain_unit
    import rfd_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int RECORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [REC_W-1:0]     i_record_in,
    input  wire logic [SLOT_W-1:0]    i_end_slot,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_record_valid,
    output logic [REC_W-1:0]          o_record_out,
    output logic [CNT_OUT_W-1:0]      o_drained_count,
    output logic [SLOT_W-1:0]         o_head_slot,
    output logic [SLOT_W-1:0]         o_tail_slot,
    output logic [CNT_OUT_W-1:0]      o_fill_level,
    output logic                      o_last
);

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int STORE_BITS = (RECORD_BITS < REC_W) ? RECORD_BITS : REC_W;

    logic [STORE_BITS-1:0] r_mem [DEPTH];
    logic [STORE_BITS-1:0] r_rd_data;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [STORE_BITS-1:0] r_rec, n_rec;
    logic [SLOT_W-1:0]     r_end, n_end;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_drained, n_drained;
    logic [CAP_W-1:0]      r_capacity, n_capacity;
    t_status               r_out_status, n_out_status;
    logic                  r_out_rvalid, n_out_rvalid;
    logic [STORE_BITS-1:0] r_out_rec, n_out_rec;
    logic [CNT_W-1:0]      r_out_count, n_out_count;
    logic                  r_last, n_last;

    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [CAP_W-1:0]      w_cap;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_end_bad;
    logic                  w_at_end;
    logic                  w_need_read;
    logic [PTR_W-1:0]      w_adv_in;
    logic [PTR_W:0]        w_adv_sum;
    logic [PTR_W-1:0]      w_adv_out;

    // Capacity in use, saturated into 1..DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CAP_W'(1);
        end else if (r_capacity > CAP_W'(DEPTH)) begin
            w_cap = CAP_W'(DEPTH);
        end else begin
            w_cap = r_capacity;
        end
    end

    // One shared pointer advance, used for the tail on enqueue and the head otherwise.
    assign w_adv_in  = (r_op == OP_ENQUEUE) ? r_tail : r_head;
    assign w_adv_sum = {1'b0, w_adv_in} + (PTR_W+1)'(1);
    assign w_adv_out = (CAP_W'(w_adv_sum) >= w_cap) ? '0 : w_adv_sum[PTR_W-1:0];

    assign w_full      = (CAP_W'(r_count) >= w_cap);
    assign w_empty     = (r_count == '0);
    assign w_end_bad   = (CAP_W'(r_end) >= w_cap);
    assign w_at_end    = (SLOT_W'(r_head) == r_end);
    assign w_need_read = ((r_op == OP_DEQUEUE) && !w_empty) ||
                         ((r_op == OP_DRAIN) && !w_end_bad && !w_at_end && !w_empty);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = w_need_read ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = r_last ? S_IDLE : S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_rec        = r_rec;
        n_end        = r_end;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_drained    = r_drained;
        n_capacity   = i_cfg_wr_en ? i_cfg_wr_data : r_capacity;
        n_out_status = r_out_status;
        n_out_rvalid = r_out_rvalid;
        n_out_rec    = r_out_rec;
        n_out_count  = r_out_count;
        n_last       = r_last;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op      = t_op'(i_operation);
                    n_rec     = i_record_in[STORE_BITS-1:0];
                    n_end     = i_end_slot;
                    n_drained = '0;
                end
            end
            S_EXEC: begin
                n_out_status = ST_OK;
                n_out_rvalid = 1'b0;
                n_out_rec    = '0;
                n_out_count  = '0;
                n_last       = 1'b1;
                case (r_op)
                    OP_ENQUEUE: begin
                        if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_tail  = w_adv_out;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_DEQUEUE: begin
                        if (w_empty) begin
                            n_out_status = ST_EMPTY;
                        end else begin
                            w_rd_en = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end
                    OP_DRAIN: begin
                        if (w_end_bad) begin
                            n_out_status = ST_BAD_SLOT;
                        end else if (w_need_read) begin
                            w_rd_en = 1'b1;
                        end
                    end
                    default: begin
                        n_out_status = ST_OK;
                    end
                endcase
            end
            S_READ: begin
                n_head       = w_adv_out;
                n_count      = r_count - CNT_W'(1);
                n_out_status = ST_OK;
                n_out_rvalid = 1'b1;
                n_out_rec    = r_rd_data;
                if (r_op == OP_DRAIN) begin
                    n_drained   = r_drained + CNT_W'(1);
                    n_out_count = r_drained + CNT_W'(1);
                    n_last      = (SLOT_W'(w_adv_out) == r_end) ||
                                  (r_count == CNT_W'(1));
                end else begin
                    n_out_count = '0;
                    n_last      = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= r_rec;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_capacity <= CAP_W'(DEPTH);
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_capacity <= n_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_rec        <= n_rec;
        r_end        <= n_end;
        r_drained    <= n_drained;
        r_out_status <= n_out_status;
        r_out_rvalid <= n_out_rvalid;
        r_out_rec    <= n_out_rec;
        r_out_count  <= n_out_count;
        r_last       <= n_last;
    end

    assign o_status        = r_out_status;
    assign o_record_valid  = r_out_rvalid;
    assign o_record_out    = REC_W'(r_out_rec);
    assign o_drained_count = CNT_OUT_W'(r_out_count);
    assign o_head_slot     = SLOT_W'(r_head);
    assign o_tail_slot     = SLOT_W'(r_tail);
    assign o_fill_level    = CNT_OUT_W'(r_count);
    assign o_last          = r_last;

    a_no_count_without_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_record_valid) |-> (o_drained_count == '0))
        else $error("drained count set on a word without a record");

    a_record_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_valid) |-> (o_status == ST_OK))
        else $error("record delivered with a failure status");

    a_not_last_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_record_valid)
        else $error("non-final word carries no record");

    a_one_side_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result word is pending");

endmodule

`default_nettype wire
